@@ sv/bbd_pkg.sv @@
package bbd_pkg;

    localparam int SYM_PER_BLOCK   = 11;
    localparam int BYTES_PER_BLOCK = 8;
    localparam int RADIX           = 58;
    localparam int VALUE_W         = 64;
    localparam int COUNT_W         = 4;
    localparam int NBYTES_W        = 4;
    localparam int DIGIT_W         = 6;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_INVALID  = 3'd1,
        ST_OVERFLOW = 3'd2,
        ST_LENGTH   = 3'd3,
        ST_TOO_BIG  = 3'd4
    } status_t;

    typedef struct packed {
        logic [VALUE_W-1:0]  value;
        logic [NBYTES_W-1:0] nbytes;
        logic                msg_last;
        status_t             status;
    } job_t;

    typedef struct packed {
        logic               valid;
        logic [DIGIT_W-1:0] digit;
    } digit_t;

    function automatic digit_t digit_of(input logic [7:0] sym);
        digit_t     res;
        logic [7:0] d;
        res.valid = 1'b1;
        d         = 8'd0;
        if (sym inside {[8'h31:8'h39]})
        begin
            d = sym - 8'h31;
        end
        else if (sym inside {[8'h41:8'h48]})
        begin
            d = sym - 8'h41 + 8'd9;
        end
        else if (sym inside {[8'h4A:8'h4E]})
        begin
            d = sym - 8'h4A + 8'd17;
        end
        else if (sym inside {[8'h50:8'h5A]})
        begin
            d = sym - 8'h50 + 8'd22;
        end
        else if (sym inside {[8'h61:8'h6B]})
        begin
            d = sym - 8'h61 + 8'd33;
        end
        else if (sym inside {[8'h6D:8'h7A]})
        begin
            d = sym - 8'h6D + 8'd44;
        end
        else
        begin
            res.valid = 1'b0;
        end
        res.digit = d[DIGIT_W-1:0];
        return res;
    endfunction

    // byte count of a final partial block, 0 where the length is not allowed
    function automatic logic [NBYTES_W-1:0] bytes_for(input logic [COUNT_W-1:0] cnt);
        logic [NBYTES_W-1:0] n;
        case (cnt)
            4'd2:    n = 4'd1;
            4'd3:    n = 4'd2;
            4'd5:    n = 4'd3;
            4'd6:    n = 4'd4;
            4'd7:    n = 4'd5;
            4'd9:    n = 4'd6;
            4'd10:   n = 4'd7;
            4'd11:   n = 4'd8;
            default: n = 4'd0;
        endcase
        return n;
    endfunction

endpackage

@@ sv/bbd_in_if.sv @@
interface bbd_in_if;

    logic       valid;
    logic       ready;
    logic [7:0] symbol;
    logic       message_last;

    modport source (output valid, output symbol, output message_last, input ready);
    modport sink   (input valid, input symbol, input message_last, output ready);

endinterface

@@ sv/bbd_out_if.sv @@
interface bbd_out_if;

    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       run_last;
    logic       message_end;
    logic [2:0] status;

    modport source (output valid, output data_byte, output run_last, output message_end,
                    output status, input ready);
    modport sink   (input valid, input data_byte, input run_last, input message_end,
                    input status, output ready);

endinterface

@@ sv/bbd_queue.sv @@
module bbd_queue
    import bbd_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output job_t pop_job,
    output logic empty
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             mem [DEPTH];
    logic [IDX_W-1:0] wr_reg, wr_next;
    logic [IDX_W-1:0] rd_reg, rd_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign full    = (cnt_reg == CNT_W'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign pop_job = mem[rd_reg];

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (do_push)
        begin
            wr_next = (wr_reg == IDX_W'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_next = (rd_reg == IDX_W'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_reg] <= push_job;
        end
    end

endmodule

@@ sv/bbd_front.sv @@
module bbd_front
    import bbd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    bbd_in_if.sink   text,
    output logic     push,
    output job_t     push_job,
    input  logic     q_full
);

    logic [VALUE_W-1:0]  block_value_reg, block_value_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic                failed_reg, failed_next;
    logic                accept;
    digit_t              dig;
    logic [VALUE_W+5:0]  prod;
    logic [VALUE_W-1:0]  nv;
    logic [COUNT_W-1:0]  cnt;
    logic [NBYTES_W-1:0] nb;
    logic [VALUE_W-1:0]  hi_mask;
    logic                last;

    assign text.ready = !q_full;
    assign accept     = text.valid && text.ready;
    assign last       = text.message_last;
    assign dig        = digit_of(text.symbol);
    assign prod       = {6'd0, block_value_reg} * (VALUE_W + 6)'(RADIX)
                        + {(VALUE_W)'(0), dig.digit};
    assign nv         = prod[VALUE_W-1:0];
    assign cnt        = count_reg + 1'b1;
    assign nb         = bytes_for(cnt);
    assign hi_mask    = ~(VALUE_W)'(0) << {nb, 3'b000};

    always_comb
    begin
        block_value_next = block_value_reg;
        count_next       = count_reg;
        failed_next      = failed_reg;
        push             = 1'b0;
        push_job.value    = '0;
        push_job.nbytes   = 4'd1;
        push_job.msg_last = last;
        push_job.status   = ST_OK;
        if (accept)
        begin
            if (failed_reg)
            begin
                if (last)
                begin
                    failed_next      = 1'b0;
                    block_value_next = '0;
                    count_next       = '0;
                end
            end
            else
            begin
                push             = 1'b1;
                block_value_next = '0;
                count_next       = '0;
                if (!dig.valid)
                begin
                    push_job.status = ST_INVALID;
                    failed_next     = !last;
                end
                else if (prod[VALUE_W+5:VALUE_W] != '0)
                begin
                    push_job.status = ST_OVERFLOW;
                    failed_next     = !last;
                end
                else if (cnt == COUNT_W'(SYM_PER_BLOCK))
                begin
                    push_job.value  = nv;
                    push_job.nbytes = NBYTES_W'(BYTES_PER_BLOCK);
                end
                else if (!last)
                begin
                    push             = 1'b0;
                    block_value_next = nv;
                    count_next       = cnt;
                end
                else if (nb == '0)
                begin
                    push_job.status = ST_LENGTH;
                end
                else if ((nv & hi_mask) != '0)
                begin
                    push_job.status = ST_TOO_BIG;
                end
                else
                begin
                    push_job.value  = nv;
                    push_job.nbytes = nb;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_value_reg <= '0;
            count_reg       <= '0;
            failed_reg      <= 1'b0;
        end
        else
        begin
            block_value_reg <= block_value_next;
            count_reg       <= count_next;
            failed_reg      <= failed_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_open_block_short : assert property (@(posedge clk) disable iff (!rst_n)
        count_reg < COUNT_W'(SYM_PER_BLOCK))
        else $error("open block holds a full block of symbols");

    a_failed_block_clear : assert property (@(posedge clk) disable iff (!rst_n)
        failed_reg |-> (count_reg == '0 && block_value_reg == '0))
        else $error("failed message kept block state");
`endif

endmodule

@@ sv/bbd_back.sv @@
module bbd_back
    import bbd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  job_t      pop_job,
    input  logic      q_empty,
    output logic      pop,
    bbd_out_if.source data
);

    logic [VALUE_W-1:0]  value_reg, value_next;
    logic [NBYTES_W-1:0] left_reg, left_next;
    logic                busy_reg, busy_next;
    logic                last_reg, last_next;
    status_t             status_reg, status_next;
    logic                out_valid_reg, out_valid_next;
    logic [7:0]          out_byte_reg, out_byte_next;
    logic                out_run_last_reg, out_run_last_next;
    logic                out_msg_end_reg, out_msg_end_next;
    status_t             out_status_reg, out_status_next;
    logic                advance, emit, finish;
    logic [NBYTES_W-1:0] pad;

    assign advance = !out_valid_reg || data.ready;
    assign emit    = advance && busy_reg;
    assign finish  = emit && (left_reg == 4'd1);
    assign pop     = !q_empty && (!busy_reg || finish);
    assign pad     = NBYTES_W'(BYTES_PER_BLOCK) - pop_job.nbytes;

    assign data.valid       = out_valid_reg;
    assign data.data_byte   = out_byte_reg;
    assign data.run_last    = out_run_last_reg;
    assign data.message_end = out_msg_end_reg;
    assign data.status      = out_status_reg;

    always_comb
    begin
        value_next        = value_reg;
        left_next         = left_reg;
        busy_next         = busy_reg;
        last_next         = last_reg;
        status_next       = status_reg;
        out_valid_next    = out_valid_reg;
        out_byte_next     = out_byte_reg;
        out_run_last_next = out_run_last_reg;
        out_msg_end_next  = out_msg_end_reg;
        out_status_next   = out_status_reg;
        if (emit)
        begin
            out_valid_next    = 1'b1;
            out_byte_next     = value_reg[VALUE_W-1 -: 8];
            out_run_last_next = (left_reg == 4'd1);
            out_msg_end_next  = (left_reg == 4'd1) && last_reg;
            out_status_next   = status_reg;
        end
        else if (advance)
        begin
            out_valid_next = 1'b0;
        end
        if (pop)
        begin
            // left-align so the next byte is always the top one
            value_next  = pop_job.value << {pad, 3'b000};
            left_next   = pop_job.nbytes;
            last_next   = pop_job.msg_last;
            status_next = pop_job.status;
            busy_next   = 1'b1;
        end
        else if (emit)
        begin
            value_next = value_reg << 8;
            left_next  = left_reg - 1'b1;
            if (finish)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            left_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            left_reg      <= left_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg        <= value_next;
        last_reg         <= last_next;
        status_reg       <= status_next;
        out_byte_reg     <= out_byte_next;
        out_run_last_reg <= out_run_last_next;
        out_msg_end_reg  <= out_msg_end_next;
        out_status_reg   <= out_status_next;
    end

`ifndef NO_ASSERTIONS
    a_busy_has_bytes : assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (left_reg != '0 && left_reg <= NBYTES_W'(BYTES_PER_BLOCK)))
        else $error("serializer busy with no bytes left");

    a_end_is_run_last : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_msg_end_reg |-> out_run_last_reg)
        else $error("message end without run end");

    a_error_single : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_status_reg != ST_OK |-> out_run_last_reg && out_byte_reg == 8'd0)
        else $error("error result is not a single zero byte");
`endif

endmodule

@@ sv/base58_block_decoder.sv @@
// Streaming base58 block decoder. One ASCII symbol is taken per cycle on text
// while the job queue (four entries by default) has room; every 11 symbols
// form a block whose 64-bit value leaves on data as 8 bytes, most significant
// first, one byte per cycle from the back-end serializer while data is ready.
// A final partial block of 2, 3, 5, 6, 7, 9 or 10 symbols gives 1 to 7 bytes.
// An error (invalid symbol, overflow, bad final length, value too big for its
// bytes) gives one zero byte carrying the status code, and the rest of that
// message is dropped without results. The serializer takes the next job as it
// sends the last byte of a run; a block's bytes follow its closing symbol via
// the job queue, the serializer's value register and the output register.
module base58_block_decoder
    import bbd_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic      clk,
    input  logic      rst_n,
    bbd_in_if.sink    text,
    bbd_out_if.source data
);

    logic push, pop, q_full, q_empty;
    job_t push_job, pop_job;

    bbd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .text     (text),
        .push     (push),
        .push_job (push_job),
        .q_full   (q_full)
    );

    bbd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (pop),
        .pop_job  (pop_job),
        .empty    (q_empty)
    );

    bbd_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .pop_job (pop_job),
        .q_empty (q_empty),
        .pop     (pop),
        .data    (data)
    );

endmodule
